@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is held.
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/mscal_pkg.sv @@
`timescale 1ns / 1ps

package mscal_pkg;

    localparam int NUM_AXES       = 3;
    localparam int BYTE_W         = 8;
    localparam int LOW_W          = 2;
    localparam int CODE_W         = 2 * BYTE_W + LOW_W;
    localparam int OFF_W          = 20;
    localparam int COEF_W         = 16;
    localparam int ROW_W          = COEF_W * NUM_AXES;
    localparam int COEF_FRAC_BITS = 14;
    localparam int V_W            = 21;
    localparam int PROD_W         = V_W + COEF_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int OUT_W          = 21;
    localparam int CODE_BIAS      = 131072;
    localparam int OUT_MAX        = 1048575;
    localparam int OUT_MIN        = -1048576;
    localparam int IN_TDATA_W     = BYTE_W * (2 * NUM_AXES + 1);
    localparam int OUT_TDATA_W    = ((NUM_AXES * OUT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W      = 3;

    typedef logic        [CODE_W-1:0] code_t;
    typedef logic signed [OFF_W-1:0]  off_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [V_W-1:0]    vec_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [OUT_W-1:0]  out_t;
    typedef logic        [ROW_W-1:0]  row_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HARD_X = 3'd0,
        CFG_HARD_Y = 3'd1,
        CFG_HARD_Z = 3'd2,
        CFG_SOFT_X = 3'd3,
        CFG_SOFT_Y = 3'd4,
        CFG_SOFT_Z = 3'd5
    } cfg_idx_t;

    // Load enables for the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

    localparam off_t HARD_X_RST = -20'sd338;
    localparam off_t HARD_Y_RST = 20'sd190;
    localparam off_t HARD_Z_RST = -20'sd766;
    localparam row_t SOFT_X_RST = 48'h4168_0073_0073;
    localparam row_t SOFT_Y_RST = 48'h0073_3EA8_FFF0;
    localparam row_t SOFT_Z_RST = 48'h0073_FFF0_3FF0;

    localparam sum_t SUM_HALF    = sum_t'(1) <<< (COEF_FRAC_BITS - 1);
    localparam sum_t SUM_OUT_MAX = sum_t'(OUT_MAX);
    localparam sum_t SUM_OUT_MIN = sum_t'(OUT_MIN);

    // Bit position of an axis's two code bits within the shared low byte
    function automatic int low_pos(input int axis);
        return LOW_W * (NUM_AXES - axis);
    endfunction

    // Floor shift (the half LSB is already in the sum), then clamp
    function automatic out_t saturate(input sum_t s);
        sum_t q;
        q = s >>> COEF_FRAC_BITS;
        if (q > SUM_OUT_MAX) begin
            return out_t'(OUT_MAX);
        end else if (q < SUM_OUT_MIN) begin
            return out_t'(OUT_MIN);
        end
        return q[OUT_W-1:0];
    endfunction

endpackage

@@ rtl/core/magnetometer_sample_calibrate.sv @@
// Registered in turn: offset-corrected code, products, row sums, field.
// Throughput: one item per cycle; a stalled output only holds back stages
// that are full, so bubbles ahead of it still take new items.
// Path: offset subtract, 3 lanes x 3 multipliers, row sum, round/clamp.
// Reset (aresetn low, synchronous): pipeline emptied, calibration
// registers return to their default offsets and matrix.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module magnetometer_sample_calibrate import mscal_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // x_high, x_mid, y_high, y_mid, z_high, z_mid, low_bits
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // field_x, field_y, field_z, one pad bit
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ROW_W-1:0]       cfg_wdata
);

    off_t     hard_iron_reg [NUM_AXES];
    row_t     soft_row_reg  [NUM_AXES];
    coef_t    lane_coef [NUM_AXES][NUM_AXES];
    prod_t    lane_prod [NUM_AXES][NUM_AXES];
    out_t     field [NUM_AXES];
    pipe_en_t en;
    logic     s1_valid_reg;
    logic     s2_valid_reg;
    logic     s3_valid_reg;
    logic     out_valid_reg;
    logic     rdy1;
    logic     rdy2;
    logic     rdy3;
    logic     rdy4;

    // Calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hard_iron_reg[0] <= HARD_X_RST;
            hard_iron_reg[1] <= HARD_Y_RST;
            hard_iron_reg[2] <= HARD_Z_RST;
            soft_row_reg[0]  <= SOFT_X_RST;
            soft_row_reg[1]  <= SOFT_Y_RST;
            soft_row_reg[2]  <= SOFT_Z_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HARD_X: hard_iron_reg[0] <= cfg_wdata[OFF_W-1:0];
                CFG_HARD_Y: hard_iron_reg[1] <= cfg_wdata[OFF_W-1:0];
                CFG_HARD_Z: hard_iron_reg[2] <= cfg_wdata[OFF_W-1:0];
                CFG_SOFT_X: soft_row_reg[0]  <= cfg_wdata;
                CFG_SOFT_Y: soft_row_reg[1]  <= cfg_wdata;
                CFG_SOFT_Z: soft_row_reg[2]  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage ready chain: a stage moves on when empty or when the next one does
    assign rdy4 = !out_valid_reg || m_tready;
    assign rdy3 = !s3_valid_reg  || rdy4;
    assign rdy2 = !s2_valid_reg  || rdy3;
    assign rdy1 = !s1_valid_reg  || rdy2;

    assign s_tready = rdy1;
    assign en.s1    = rdy1 && s_tvalid;
    assign en.s2    = rdy2 && s1_valid_reg;
    assign en.s3    = rdy3 && s2_valid_reg;
    assign en.s4    = rdy4 && s3_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                s1_valid_reg <= s_tvalid;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4) begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Lane a takes coefficient slot a of every row (slot 0 in the top bits)
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int r = 0; r < NUM_AXES; r++) begin
                lane_coef[a][r] = soft_row_reg[r][COEF_W*(NUM_AXES-1-a) +: COEF_W];
            end
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        mscal_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .high   (s_tdata[BYTE_W*(2*a)     +: BYTE_W]),
            .mid    (s_tdata[BYTE_W*(2*a + 1) +: BYTE_W]),
            .lo     (s_tdata[BYTE_W*2*NUM_AXES + low_pos(a) +: LOW_W]),
            .offset (hard_iron_reg[a]),
            .coef   (lane_coef[a]),
            .prod   (lane_prod[a])
        );
    end

    mscal_merge u_merge (
        .aclk  (aclk),
        .en    (en),
        .prod  (lane_prod),
        .field (field)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - NUM_AXES*OUT_W){1'b0}}, field[2], field[1], field[0]};

    `ASSERT_IMPLIES(a_bubble_takes_item, aclk, aresetn, !s1_valid_reg, s_tready, "empty first stage refused an item")
    `ASSERT_IMPLIES(a_no_stall_when_sink_ready, aclk, aresetn, m_tready, s_tready, "pipeline stalled with sink ready")
    `ASSERT_HOLDS(a_accept_enters, aclk, aresetn, (s_tvalid && s_tready) |=> s1_valid_reg, "accepted item lost at entry")
    `ASSERT_HOLDS(a_out_from_stage3, aclk, aresetn, $rose(m_tvalid) |-> $past(s3_valid_reg), "result appeared without a sum")

endmodule

@@ rtl/core/mscal_lane.sv @@
`timescale 1ns / 1ps

// One axis: unbias and offset the raw code, then scale it by the column of
// coefficients that this axis feeds in each output row.
module mscal_lane import mscal_pkg::*; (
    input  logic              aclk,
    input  pipe_en_t          en,
    input  logic [BYTE_W-1:0] high,
    input  logic [BYTE_W-1:0] mid,
    input  logic [LOW_W-1:0]  lo,
    input  off_t              offset,
    input  coef_t             coef [NUM_AXES],
    output prod_t             prod [NUM_AXES]
);

    code_t code;
    vec_t  v_next;
    vec_t  v_reg;
    prod_t prod_next [NUM_AXES];
    prod_t prod_reg  [NUM_AXES];

    assign code   = {high, mid, lo};
    assign v_next = {{(V_W - CODE_W){1'b0}}, code} - vec_t'(CODE_BIAS)
                  - {{(V_W - OFF_W){offset[OFF_W-1]}}, offset};

    // Operands sign-extended to the product width; effectively 21 x 16 bits
    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            prod_next[r] = prod_t'(v_reg) * prod_t'(coef[r]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            v_reg <= v_next;
        end
        if (en.s2) begin
            for (int r = 0; r < NUM_AXES; r++) begin
                prod_reg[r] <= prod_next[r];
            end
        end
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/mscal_merge.sv @@
`timescale 1ns / 1ps

// Adds the lane products per output row, rounds and clamps.
module mscal_merge import mscal_pkg::*; (
    input  logic     aclk,
    input  pipe_en_t en,
    input  prod_t    prod [NUM_AXES][NUM_AXES],   // [axis][row]
    output out_t     field [NUM_AXES]
);

    sum_t sum_next  [NUM_AXES];
    sum_t sum_reg   [NUM_AXES];
    out_t field_reg [NUM_AXES];

    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            sum_next[r] = SUM_HALF;
            for (int a = 0; a < NUM_AXES; a++) begin
                sum_next[r] = sum_next[r] + sum_t'(prod[a][r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int r = 0; r < NUM_AXES; r++) begin
            if (en.s3) begin
                sum_reg[r] <= sum_next[r];
            end
            if (en.s4) begin
                field_reg[r] <= saturate(sum_reg[r]);
            end
        end
    end

    assign field = field_reg;

endmodule
